// ===== rtl/core/tun_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and transfer types for the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_WIDTH       = 16;
    localparam int UNIT_WIDTH        = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [UNIT_WIDTH-1:0] unit_x;
        logic signed [UNIT_WIDTH-1:0] unit_y;
        logic signed [UNIT_WIDTH-1:0] unit_z;
        logic                         degenerate;
    } tri_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/triangle_unit_normal.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit normal of a triangle: cross product (B-A)x(C-A), normalized to Q1.F.
//
// Usage:
//   s_valid/s_ready/s_data carry one triangle (three Q8.8 vertices) per
//   transfer; m_valid/m_ready/m_data return its normal in signed Q1.F plus a
//   degenerate flag (flag set, components zero, when the cross product is 0).
//   One triangle is taken every cycle while the output is taken or empty;
//   the datapath is fully pipelined with six front stages (edges, products,
//   cross product, partial squares, squares, square sum), one shift/subtract
//   stage per result bit for the normalization, and the output register that
//   drives m_valid.
//   A stall on m_ready freezes the whole pipeline; s_ready drops with it and
//   nothing is lost or repeated. Synchronous active-low reset empties the
//   pipeline; payload registers are not reset.
//   OUT_FRAC_BITS ranges from 8 to 14 (results fit the 16-bit fields).
// ----------------------------------------------------------------------------
module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      s_valid,
    output logic     s_ready,
    input  tri_in_t  s_data,
    output logic     m_valid,
    input  wire      m_ready,
    output tri_out_t m_data
);

    localparam int F   = OUT_FRAC_BITS;
    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 1;
    localparam int PW  = 2 * EW;
    localparam int MW  = PW;
    localparam int NW  = PW + 1;
    localparam int HW  = (MW + 1) / 2;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int RW  = SQW + 2 * F + 6;
    localparam int QW  = F + 1;
    localparam int NS  = F + 1;

    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    // stage 1: edges
    logic                 v1_reg;
    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] g_reg [3];
    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p_reg [3];
    logic signed [PW-1:0] m_reg [3];
    // stage 3: cross product magnitude and sign
    logic                 v3_reg;
    logic        [MW-1:0] mag_reg [3];
    logic                 neg3_reg [3];
    // stage 4: partial squares
    logic                 v4_reg;
    logic      [2*HW-1:0] ll_reg [3];
    logic      [2*HW-1:0] lh_reg [3];
    logic      [2*HW-1:0] hh_reg [3];
    logic                 neg4_reg [3];
    // stage 5: squares
    logic                 v5_reg;
    logic       [SQW-1:0] sq_reg [3];
    logic                 neg5_reg [3];

    // normalization pipeline, index 0 is the square-sum stage
    logic                 vi_reg   [NS+1];
    logic        [SW-1:0] sum_reg  [NS];
    logic                 zero_reg [NS+1];
    logic        [RW-1:0] r_reg    [NS][3];
    logic        [RW-1:0] w_reg    [NS][3];
    logic        [QW-1:0] q_reg    [NS+1][3];
    logic                 neg_reg  [NS+1][3];

    logic signed [EW-1:0] va [3];
    logic signed [EW-1:0] vb [3];
    logic signed [EW-1:0] vc [3];

    assign va[0] = EW'(s_data.a_x);
    assign va[1] = EW'(s_data.a_y);
    assign va[2] = EW'(s_data.a_z);
    assign vb[0] = EW'(s_data.b_x);
    assign vb[1] = EW'(s_data.b_y);
    assign vb[2] = EW'(s_data.b_z);
    assign vc[0] = EW'(s_data.c_x);
    assign vc[1] = EW'(s_data.c_y);
    assign vc[2] = EW'(s_data.c_z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            vi_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vi_reg[0] <= v5_reg;
        end
    end

    generate
        for (genvar i = 0; i < 3; i++) begin : g_front
            localparam int J = (i + 1) % 3;
            localparam int K = (i + 2) % 3;

            logic signed [NW-1:0] diff;
            logic        [MW-1:0] absd;
            logic        [HW-1:0] lo;
            logic        [HW-1:0] hi;

            assign diff = NW'(p_reg[i]) - NW'(m_reg[i]);
            assign absd = diff[NW-1] ? MW'(-diff) : MW'(diff);
            assign lo   = mag_reg[i][HW-1:0];
            assign hi   = HW'(mag_reg[i] >> HW);

            always_ff @(posedge aclk) begin
                if (en) begin
                    e_reg[i]         <= vb[i] - va[i];
                    g_reg[i]         <= vc[i] - va[i];
                    p_reg[i]         <= PW'(e_reg[J] * g_reg[K]);
                    m_reg[i]         <= PW'(e_reg[K] * g_reg[J]);
                    mag_reg[i]       <= absd;
                    neg3_reg[i]      <= diff[NW-1];
                    ll_reg[i]        <= lo * lo;
                    lh_reg[i]        <= lo * hi;
                    hh_reg[i]        <= hi * hi;
                    neg4_reg[i]      <= neg3_reg[i];
                    sq_reg[i]        <= (SQW'(hh_reg[i]) << (2 * HW))
                                      + (SQW'(lh_reg[i]) << (HW + 1))
                                      + SQW'(ll_reg[i]);
                    neg5_reg[i]      <= neg4_reg[i];
                    r_reg[0][i]      <= RW'(sq_reg[i]) << (2 * F);
                    w_reg[0][i]      <= '0;
                    q_reg[0][i]      <= '0;
                    neg_reg[0][i]    <= neg5_reg[i];
                end
            end
        end
    endgenerate

    logic [SW-1:0] sum_next;
    assign sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg[0]  <= sum_next;
            zero_reg[0] <= (sum_next == '0);
        end
    end

    // one result bit per stage: keep R = n^2*2^2F - q^2*S and W = q*S
    generate
        for (genvar k = 0; k < NS; k++) begin : g_iter
            localparam int B = F - k;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vi_reg[k+1] <= 1'b0;
                end else if (en) begin
                    vi_reg[k+1] <= vi_reg[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    zero_reg[k+1] <= zero_reg[k];
                end
            end

            if (k < NS - 1) begin : g_sum
                always_ff @(posedge aclk) begin
                    if (en) begin
                        sum_reg[k+1] <= sum_reg[k];
                    end
                end
            end

            for (genvar i = 0; i < 3; i++) begin : g_lane
                logic [RW-1:0] trial;
                logic          take;

                assign trial = (w_reg[k][i] << (B + 1)) + (RW'(sum_reg[k]) << (2 * B));
                assign take  = (trial <= r_reg[k][i]);

                always_ff @(posedge aclk) begin
                    if (en) begin
                        q_reg[k+1][i]   <= q_reg[k][i] | (QW'(take) << B);
                        neg_reg[k+1][i] <= neg_reg[k][i];
                    end
                end

                if (k < NS - 1) begin : g_rem
                    always_ff @(posedge aclk) begin
                        if (en) begin
                            r_reg[k+1][i] <= take ? (r_reg[k][i] - trial) : r_reg[k][i];
                            w_reg[k+1][i] <= take ? (w_reg[k][i] + (RW'(sum_reg[k]) << B))
                                                  : w_reg[k][i];
                        end
                    end
                end
            end
        end
    endgenerate

    // output register
    logic [UNIT_WIDTH-1:0] comp [3];

    generate
        for (genvar i = 0; i < 3; i++) begin : g_out
            logic [UNIT_WIDTH-1:0] qx;
            assign qx      = UNIT_WIDTH'(q_reg[NS][i]);
            assign comp[i] = zero_reg[NS] ? '0 : (neg_reg[NS][i] ? (~qx + 1'b1) : qx);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= vi_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data.unit_x     <= comp[0];
            m_data.unit_y     <= comp[1];
            m_data.unit_z     <= comp[2];
            m_data.degenerate <= zero_reg[NS];
        end
    end

    a_degenerate_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.unit_x == '0 && m_data.unit_y == '0 && m_data.unit_z == '0)
        else $error("degenerate result with nonzero components");

    a_unit_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.unit_x <= $signed(UNIT_WIDTH'(1 << F)) &&
            m_data.unit_x >= -$signed(UNIT_WIDTH'(1 << F)) &&
            m_data.unit_y <= $signed(UNIT_WIDTH'(1 << F)) &&
            m_data.unit_y >= -$signed(UNIT_WIDTH'(1 << F)) &&
            m_data.unit_z <= $signed(UNIT_WIDTH'(1 << F)) &&
            m_data.unit_z >= -$signed(UNIT_WIDTH'(1 << F)))
        else $error("normal component out of range");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Triangle unit normal testbench. Drives triangles over the input channel with
// random gaps, predicts each normal with exact integer arithmetic and a
// bit-serial search for the truncated unit component, and compares every
// result transfer against the oldest predicted normal.
// ----------------------------------------------------------------------------
module tb;
    import tun_pkg::*;

    localparam int FRAC    = OUT_FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 8;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tri_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    tri_out_t m_data;

    tri_out_t normal_q[$];
    int       mismatches;
    int       normals_seen;
    int       rx_hold_cycles;

    triangle_unit_normal #(.OUT_FRAC_BITS(FRAC)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    // Largest q with q*q*sum <= n*n*2^(2F), signed by n.
    function automatic logic signed [UNIT_WIDTH-1:0] unit_comp(
        input logic signed [35:0] n, input logic [71:0] sum);
        logic [35:0]  mag;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [31:0]  q;
        logic [31:0]  t;
        mag = n[35] ? 36'(-n) : 36'(n);
        rhs = (128'(mag) * 128'(mag)) << (2 * FRAC);
        q = 0;
        for (int b = FRAC; b >= 0; b--) begin
            t = q | (32'd1 << b);
            lhs = 128'(t) * 128'(t) * 128'(sum);
            if (lhs <= rhs) q = t;
        end
        return n[35] ? UNIT_WIDTH'(-q) : UNIT_WIDTH'(q);
    endfunction

    function automatic tri_out_t predict_normal(input tri_in_t t);
        logic signed [17:0] ex, ey, ez, gx, gy, gz;
        logic signed [35:0] nx, ny, nz;
        logic [71:0]        sum;
        tri_out_t           r;
        ex = 18'(t.b_x) - 18'(t.a_x);
        ey = 18'(t.b_y) - 18'(t.a_y);
        ez = 18'(t.b_z) - 18'(t.a_z);
        gx = 18'(t.c_x) - 18'(t.a_x);
        gy = 18'(t.c_y) - 18'(t.a_y);
        gz = 18'(t.c_z) - 18'(t.a_z);
        nx = 36'(ey) * 36'(gz) - 36'(ez) * 36'(gy);
        ny = 36'(ez) * 36'(gx) - 36'(ex) * 36'(gz);
        nz = 36'(ex) * 36'(gy) - 36'(ey) * 36'(gx);
        sum = 72'(72'(nx) * 72'(nx)) + 72'(72'(ny) * 72'(ny)) + 72'(72'(nz) * 72'(nz));
        r = '0;
        if (sum == 0) begin
            r.degenerate = 1'b1;
        end else begin
            r.unit_x = unit_comp(nx, sum);
            r.unit_y = unit_comp(ny, sum);
            r.unit_z = unit_comp(nz, sum);
        end
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(0, 2);
    endfunction

    // valid stays high across back-to-back transfers; it drops only for a gap
    task automatic send_triangle(input tri_in_t t, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        normal_q.push_back(predict_normal(t));
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: random stalls, or a long forced hold-off.
    bit rx_gaps;
    initial begin
        int g;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                g = gap_len();
                rx_hold_cycles = g;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        tri_out_t exp_n;
        if (aresetn && m_valid && m_ready) begin
            normals_seen++;
            if (normal_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected normal %p", m_data);
            end else begin
                exp_n = normal_q.pop_front();
                if (m_data.unit_x !== exp_n.unit_x || m_data.unit_y !== exp_n.unit_y ||
                    m_data.unit_z !== exp_n.unit_z ||
                    m_data.degenerate !== exp_n.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("normal mismatch: exp %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                                 exp_n.unit_x, exp_n.unit_y, exp_n.unit_z, exp_n.degenerate,
                                 m_data.unit_x, m_data.unit_y, m_data.unit_z,
                                 m_data.degenerate);
                end
            end
        end
    end

    function automatic tri_in_t mk(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        tri_in_t t;
        t.a_x = COORD_WIDTH'(ax); t.a_y = COORD_WIDTH'(ay); t.a_z = COORD_WIDTH'(az);
        t.b_x = COORD_WIDTH'(bx); t.b_y = COORD_WIDTH'(by); t.b_z = COORD_WIDTH'(bz);
        t.c_x = COORD_WIDTH'(cx); t.c_y = COORD_WIDTH'(cy); t.c_z = COORD_WIDTH'(cz);
        return t;
    endfunction

    function automatic logic [15:0] rand_coord(input int mode);
        case (mode)
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 64)) - 32);
            2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    task automatic test_directed();
        send_triangle(mk(0, 0, 0, 256, 0, 0, 0, 256, 0), 0);
        send_triangle(mk(0, 0, 0, 0, 256, 0, 256, 0, 0), 0);
        send_triangle(mk(0, 0, 0, 0, 256, 0, 0, 0, 256), 0);
        send_triangle(mk(0, 0, 0, 0, 0, 256, 256, 0, 0), 0);
        send_triangle(mk(5, 5, 5, 5, 5, 5, 5, 5, 5), 0);
        send_triangle(mk(0, 0, 0, 100, 100, 100, 200, 200, 200), 0);
        send_triangle(mk(0, 0, 0, 0, 0, 0, 300, -7, 9), 0);
        send_triangle(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                         -32768, 32767, -32768), 0);
        send_triangle(mk(32767, 32767, 32767, -32768, 32767, 32767,
                         32767, 32767, -32768), 0);
        send_triangle(mk(-32768, 32767, -32768, 32767, -32768, 32767,
                         -32768, -32768, 32767), 0);
        send_triangle(mk(32767, -32768, 0, -32768, 32767, 0, 32767, 32767, 32767), 0);
        send_triangle(mk(0, 0, 0, 1, 0, 0, 0, 1, 0), 0);
        send_triangle(mk(0, 0, 0, 1, 1, 0, -1, 1, 1), 0);
        send_triangle(mk(-1, -1, -1, 0, 0, 0, 1, 2, 3), 0);
        send_triangle(mk(0, 0, 0, 256, 256, 0, 0, 256, 256), 0);
    endtask

    task automatic test_random(input int count);
        tri_in_t t;
        int      mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 3);
            t.a_x = rand_coord(mode); t.a_y = rand_coord(mode); t.a_z = rand_coord(mode);
            t.b_x = rand_coord(mode); t.b_y = rand_coord(mode); t.b_z = rand_coord(mode);
            t.c_x = rand_coord(mode); t.c_y = rand_coord(mode); t.c_z = rand_coord(mode);
            if ($urandom_range(0, 15) == 0) begin
                t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z;
            end
            send_triangle(t, (i % 100) >= 30);
        end
    endtask

    task automatic test_backpressure();
        rx_hold_cycles = 3 * LATENCY;
        test_random(60);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (normal_q.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    initial begin
        mismatches     = 0;
        normals_seen   = 0;
        rx_gaps        = 1'b0;
        rx_hold_cycles = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        rx_gaps = 1'b1;
        test_random(600);
        test_backpressure();
        drain();
        if (mismatches == 0 && normal_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== triangle_unit_normal.f =====
rtl/core/tun_pkg.sv
rtl/core/triangle_unit_normal.sv
tb/tb.sv
